### design/ttcb_pkg.sv
`default_nettype none

package ttcb_pkg;

	// Default sizes of the cell store and the screen geometry.
	localparam int DEF_MAX_CELLS = 8192;
	localparam int DEF_MAX_COLS  = 128;
	localparam int DEF_MAX_ROWS  = 64;

	// Geometry register values after reset.
	localparam int COLS_RESET = 80;
	localparam int ROWS_RESET = 25;

	// Configuration port.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 8'd1;

	// Commands and special characters.
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [7:0] CHAR_NUL = 8'd0;
	localparam logic [7:0] CHAR_BS  = 8'd8;
	localparam logic [7:0] CHAR_NL  = 8'd10;

	// Redraw hints.
	localparam logic [1:0] DIRTY_NONE   = 2'd0;
	localparam logic [1:0] DIRTY_CELL   = 2'd1;
	localparam logic [1:0] DIRTY_SCREEN = 2'd2;

	typedef struct packed {
		logic       command;
		logic [7:0] char_code;
		logic [6:0] cell_column;
		logic [5:0] cell_row;
	} item_t;

	typedef struct packed {
		logic [7:0] cursor_column;
		logic [5:0] cursor_row;
		logic [1:0] dirty_kind;
		logic [6:0] dirty_column;
		logic [5:0] dirty_row;
		logic [7:0] read_char;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clr_step;
		logic       geom_init;
		logic       geom_step;
		logic       cfg_we;
		logic       load;
		logic       nl_move;
		logic       bs_move;
		logic       scroll_init;
		logic       scroll_step;
		logic       scroll_end;
		logic       mul;
		logic       addr;
		logic       mem_rd;
		logic       mem_wr;
		logic       emit;
		logic       advance;
		logic [1:0] kind;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic geom_ok;
		logic is_read;
		logic is_nul;
		logic is_nl;
		logic is_bs;
		logic at_bottom;
		logic line_full;
		logic scroll_last;
	} dp_status_t;

endpackage

`default_nettype wire

### design/ttcb_datapath.sv
`default_nettype none

module ttcb_datapath import ttcb_pkg::*; #(
	parameter int MAX_CELLS = DEF_MAX_CELLS,
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire item_t                  item,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire ctrl_cmd_t              cmd,
	output dp_status_t                  status,
	output result_t                     result
);

	localparam int AW      = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SW      = $clog2(MAX_CELLS + 1);
	localparam int IW      = SW + 1;
	localparam int CW      = $clog2(MAX_COLS + 1);
	localparam int RW      = $clog2(MAX_ROWS + 1);
	localparam int RSW     = (RW > 6) ? RW : 6;
	localparam int PW      = RSW + CW;
	localparam int COL_LIM = (MAX_COLS < MAX_CELLS) ? MAX_COLS : MAX_CELLS;

	logic [7:0]    columns_q;
	logic [6:0]    rows_q;
	logic [CW-1:0] c_eff_q;
	logic [RW-1:0] r_eff_q;
	logic [SW-1:0] size_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] ring_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] cnt_q;
	item_t         item_q;
	logic [SW-1:0] prod_q;
	logic [AW-1:0] idx_q;
	logic [7:0]    rdata_q;
	result_t       out_q;

	logic [7:0]    mem [0:MAX_CELLS-1];

	logic [CW-1:0]    cols_clamped;
	logic [RW-1:0]    rows_clamped;
	logic [CW+RW-1:0] geom_prod;
	logic             geom_ok;
	logic             is_read;
	logic             in_range;
	logic [RSW-1:0]   row_sel;
	logic [PW-1:0]    mul_full;
	logic [IW-1:0]    col_sel;
	logic [IW-1:0]    addr_sum;
	logic [IW-1:0]    addr_wrap;
	logic [IW-1:0]    ring_sum;
	logic [AW-1:0]    ring_next;
	logic [IW-1:0]    ptr_inc;
	logic [AW-1:0]    ptr_wrap;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [7:0]       mem_wdata;

	// Register values out of range act as the nearest legal bound.
	always_comb begin
		if (columns_q == '0) begin
			cols_clamped = CW'(1);
		end else if (32'(columns_q) > COL_LIM) begin
			cols_clamped = CW'(COL_LIM);
		end else begin
			cols_clamped = CW'(columns_q);
		end
		if (rows_q == '0) begin
			rows_clamped = RW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			rows_clamped = RW'(MAX_ROWS);
		end else begin
			rows_clamped = RW'(rows_q);
		end
	end

	// The row count steps down until the screen fits in the cell store.
	assign geom_prod = c_eff_q * r_eff_q;
	assign geom_ok   = !((32'(geom_prod) > MAX_CELLS) && (r_eff_q > RW'(1)));

	assign is_read  = (item_q.command == CMD_READ);
	assign in_range = (32'(item_q.cell_column) < 32'(c_eff_q)) &&
		(32'(item_q.cell_row) < 32'(r_eff_q));

	assign row_sel  = is_read ? RSW'(item_q.cell_row) : RSW'(row_q);
	assign mul_full = row_sel * c_eff_q;
	assign col_sel  = is_read ? IW'(item_q.cell_column) : IW'(col_q);

	// Offset and in-screen position are each below the ring size, so one
	// subtraction reduces the sum.
	assign addr_sum  = IW'(ring_q) + IW'(prod_q) + col_sel;
	assign addr_wrap = (addr_sum >= IW'(size_q)) ? (addr_sum - IW'(size_q)) : addr_sum;

	assign ring_sum  = IW'(ring_q) + IW'(c_eff_q);
	assign ring_next = (ring_sum >= IW'(size_q)) ? AW'(ring_sum - IW'(size_q)) : AW'(ring_sum);

	assign ptr_inc  = IW'(ptr_q) + IW'(1);
	assign ptr_wrap = (ptr_inc == IW'(size_q)) ? '0 : AW'(ptr_inc);

	assign mem_we    = cmd.clr_step | cmd.scroll_step | cmd.mem_wr;
	assign mem_waddr = cmd.mem_wr ? idx_q : ptr_q;
	assign mem_wdata = (cmd.mem_wr && (item_q.char_code != CHAR_BS)) ? item_q.char_code : 8'd0;

	always_comb begin
		status.clr_last    = (ptr_q == AW'(MAX_CELLS - 1));
		status.geom_ok     = geom_ok;
		status.is_read     = is_read;
		status.is_nul      = !is_read && (item_q.char_code == CHAR_NUL);
		status.is_nl       = !is_read && (item_q.char_code == CHAR_NL);
		status.is_bs       = !is_read && (item_q.char_code == CHAR_BS);
		status.at_bottom   = (row_q >= (r_eff_q - RW'(1)));
		status.line_full   = (col_q >= c_eff_q);
		status.scroll_last = (cnt_q == (c_eff_q - CW'(1)));
	end

	// Geometry, cursor and ring offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= 8'(COLS_RESET);
			rows_q    <= 7'(ROWS_RESET);
			c_eff_q   <= CW'(1);
			r_eff_q   <= RW'(1);
			size_q    <= SW'(1);
			col_q     <= '0;
			row_q     <= '0;
			ring_q    <= '0;
		end else begin
			if (cmd.cfg_we) begin
				case (cfg_index)
					REG_COLUMNS: columns_q <= cfg_data;
					REG_ROWS:    rows_q    <= cfg_data[6:0];
					default:     ;
				endcase
				col_q  <= '0;
				row_q  <= '0;
				ring_q <= '0;
			end
			if (cmd.geom_init) begin
				c_eff_q <= cols_clamped;
				r_eff_q <= rows_clamped;
			end
			if (cmd.geom_step) begin
				if (geom_ok) begin
					size_q <= SW'(geom_prod);
				end else begin
					r_eff_q <= r_eff_q - RW'(1);
				end
			end
			if (cmd.nl_move) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end
			if (cmd.bs_move) begin
				if (col_q == '0 && row_q != '0) begin
					col_q <= c_eff_q - CW'(1);
					row_q <= row_q - RW'(1);
				end else if (col_q != '0) begin
					col_q <= col_q - CW'(1);
				end
			end
			if (cmd.scroll_end) begin
				col_q  <= '0;
				row_q  <= r_eff_q - RW'(1);
				ring_q <= ring_next;
			end
			if (cmd.emit && cmd.advance) begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Sweep pointer, shared by the clearing pass after reset and the row
	// clear of a scroll.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				ptr_q <= AW'(ptr_inc);
			end
			if (cmd.scroll_init) begin
				ptr_q <= ring_q;
				cnt_q <= '0;
			end
			if (cmd.scroll_step) begin
				ptr_q <= ptr_wrap;
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Item, address and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.mul) begin
			prod_q <= SW'(mul_full);
		end
		if (cmd.addr) begin
			idx_q <= AW'(addr_wrap);
		end
		if (cmd.emit) begin
			out_q.cursor_column <= cmd.advance ? 8'(col_q + CW'(1)) : 8'(col_q);
			out_q.cursor_row    <= 6'(row_q);
			out_q.dirty_kind    <= cmd.kind;
			out_q.dirty_column  <= (cmd.kind == DIRTY_CELL) ? 7'(col_q) : 7'd0;
			out_q.dirty_row     <= (cmd.kind == DIRTY_CELL) ? 6'(row_q) : 6'd0;
			out_q.read_char     <= (is_read && in_range) ? rdata_q : 8'd0;
		end
	end

	// Cell store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[idx_q];
		end
	end

	assign result = out_q;

endmodule

`default_nettype wire

### design/ttcb_ctrl.sv
`default_nettype none

module ttcb_ctrl import ttcb_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire dp_status_t             status,
	output logic                        busy,
	output logic                        cfg_ready,
	output logic                        done,
	output ctrl_cmd_t                   cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_GINIT,
		S_GSTEP,
		S_IDLE,
		S_DECODE,
		S_SCROLL,
		S_SCROLL_END,
		S_MUL,
		S_ADDR,
		S_MEM,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;
	logic   scrolled_q;
	logic   is_char;

	assign cfg_ready = !busy_q && !start;
	assign busy      = busy_q;
	assign done      = done_q;
	assign is_char   = !status.is_read && !status.is_nul && !status.is_nl && !status.is_bs;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = S_GINIT;
				end
			end
			S_GINIT: begin
				cmd.geom_init = 1'b1;
				state_d       = S_GSTEP;
			end
			S_GSTEP: begin
				cmd.geom_step = 1'b1;
				if (status.geom_ok) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cfg_valid && cfg_ready) begin
					if (cfg_index inside {REG_COLUMNS, REG_ROWS}) begin
						cmd.cfg_we = 1'b1;
						state_d    = S_GINIT;
					end
				end else if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (status.is_read) begin
					state_d = S_MUL;
				end else if (status.is_nul) begin
					state_d = S_EMIT;
				end else if (status.is_nl) begin
					if (status.at_bottom) begin
						cmd.scroll_init = 1'b1;
						state_d         = S_SCROLL;
					end else begin
						cmd.nl_move = 1'b1;
						state_d     = S_EMIT;
					end
				end else if (status.is_bs) begin
					cmd.bs_move = 1'b1;
					state_d     = S_MUL;
				end else if (status.line_full) begin
					// A full line wraps before the character is written.
					if (status.at_bottom) begin
						cmd.scroll_init = 1'b1;
						state_d         = S_SCROLL;
					end else begin
						cmd.nl_move = 1'b1;
						state_d     = S_MUL;
					end
				end else begin
					state_d = S_MUL;
				end
			end
			S_SCROLL: begin
				cmd.scroll_step = 1'b1;
				if (status.scroll_last) begin
					state_d = S_SCROLL_END;
				end
			end
			S_SCROLL_END: begin
				cmd.scroll_end = 1'b1;
				state_d        = status.is_nl ? S_EMIT : S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = S_MEM;
			end
			S_MEM: begin
				cmd.mem_rd = status.is_read;
				cmd.mem_wr = !status.is_read;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit    = 1'b1;
				cmd.advance = is_char;
				if (status.is_bs) begin
					cmd.kind = DIRTY_CELL;
				end else if (is_char) begin
					cmd.kind = scrolled_q ? DIRTY_SCREEN : DIRTY_CELL;
				end else if (status.is_nl) begin
					cmd.kind = scrolled_q ? DIRTY_SCREEN : DIRTY_NONE;
				end else begin
					cmd.kind = DIRTY_NONE;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			busy_q     <= 1'b1;
			done_q     <= 1'b0;
			scrolled_q <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_q == S_EMIT);
			if (state_q == S_DECODE) begin
				scrolled_q <= 1'b0;
			end else if (state_q == S_SCROLL_END) begin
				scrolled_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### design/text_terminal_cell_buffer.sv
`default_nettype none

// Character-cell terminal store with a scrolling ring of rows.
// Items enter on item when start is high and busy is low. Each item gives
// exactly one result on result, valid for the single cycle in which done
// is high; the receiver cannot hold it off and takes it at that edge.
// The geometry registers (columns, rows) are written through cfg_valid /
// cfg_ready with cfg_index and cfg_data; cfg_ready is high only while the
// block is idle and start is low. A write homes the cursor and the ring.
// Steps, from the accepting edge to the done cycle:
//   zero character or newline without scroll: decode, emit;
//   read, write or backspace: decode, multiply, address reduce, memory
//   access on the cell store, emit;
//   scroll: adds the row clear, one cell per cycle, and its end step.
// A write to columns or rows then settles the screen geometry, with busy high.
// After reset the block sweeps the whole cell store to zero, then settles
// the geometry; busy stays high throughout.
// busy drops in the cycle that done rises, so the next item can follow.

module text_terminal_cell_buffer import ttcb_pkg::*; #(
	parameter int MAX_CELLS = DEF_MAX_CELLS,
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire item_t                  item,
	output logic                        done,
	output result_t                     result,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	ttcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.status    (status),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.done      (done),
		.cmd       (cmd)
	);

	ttcb_datapath #(
		.MAX_CELLS (MAX_CELLS),
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

`default_nettype wire

### design/ttcb_checker.sv
`default_nettype none

module ttcb_checker import ttcb_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    done,
	input wire logic    cfg_valid,
	input wire logic    cfg_ready,
	input wire result_t result
);

	// A result only ends a transaction that was in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a transaction in progress");

	// One result per transaction: never two strobes back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high in two consecutive cycles");

	// An accepted item keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after an accepted item");

	// Configuration is only taken while no item is in progress.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> (!busy && !start))
		else $error("configuration write taken while busy");

	// The redraw hint carries only its three defined codes.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.dirty_kind != 2'd3))
		else $error("undefined redraw hint on result");

endmodule

bind text_terminal_cell_buffer ttcb_checker u_ttcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.result    (result)
);

`default_nettype wire
